/* rtl/core/lifo_stack_with_search_macros.svh */
// assertion macros for the lifo stack with search checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lss: property violated");

// next-cycle implication, disabled during reset
`define LSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lss: property violated");

`endif

/* rtl/core/lss_pkg.sv */
// shared types and constants for the lifo stack with search
// no dependencies
package lss_pkg;

  // default sizes
  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned QueueDepth   = 2;

  // operation codes on the input beat
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  // classified command handed to the back end
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_PUSH,
    CMD_POP,
    CMD_SEARCH
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_SEARCH
  } bk_state_e;

endpackage

/* rtl/core/lifo_stack_with_search.sv */
// Bounded LIFO stack of signed words with push, pop and search.
// Input channel: in_valid_i/in_stall_o carry operation_i (0 push, 1 pop,
// 2 search, 3 no-op) and value_i. Output channel: out_valid_o/out_stall_i
// carry one result beat per input beat: status_o, entry_count_o,
// popped_value_o, found_o and position_o.
// Each beat passes the input register, the command queue and the result
// register; a pop of a non-empty stack first reads its top entry into the
// memory read register, and a search of a non-empty stack walks up from the
// bottom entry, one stored entry per cycle through the single memory read
// port, to a match or the top. A push or no-op is taken every cycle while
// the output is not stalled; a pop or search holds the sequencer until done.
// A two-entry command queue sits between the input register and the
// sequencer, so beats keep arriving while a search walks the stack.
// Reset empties the stack and drops all queued and pending beats; memory
// contents are not cleared and need no clearing pass.
// A stalled result beat holds in the output register; the sequencer then
// waits, the queue fills and finally in_stall_o rises.
// depends on lss_pkg, lss_front, lss_queue, lss_back
module lifo_stack_with_search #(
  parameter int unsigned DEPTH      = lss_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = lss_pkg::DataWidthDef,
  localparam int unsigned CountWidth = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lss_pkg::status_e             status_o,
  output logic [CountWidth-1:0]        entry_count_o,
  output logic signed [DATA_WIDTH-1:0] popped_value_o,
  output logic                         found_o,
  output logic [CountWidth-1:0]        position_o
);
  import lss_pkg::*;

  logic                  fr_valid, fr_stall;
  cmd_e                  fr_cmd;
  logic [DATA_WIDTH-1:0] fr_word;
  logic                  q_valid, q_stall;
  cmd_e                  q_cmd;
  logic [DATA_WIDTH-1:0] q_word;

  // accept and classify
  lss_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .fr_valid_o (fr_valid),
    .fr_stall_i (fr_stall),
    .fr_cmd_o   (fr_cmd),
    .fr_word_o  (fr_word)
  );

  // decoupling queue
  lss_queue #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_stall_o(fr_stall),
    .wr_cmd_i  (fr_cmd),
    .wr_word_i (fr_word),
    .rd_valid_o(q_valid),
    .rd_stall_i(q_stall),
    .rd_cmd_o  (q_cmd),
    .rd_word_o (q_word)
  );

  // execute against the stack
  lss_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_stall_o     (q_stall),
    .q_cmd_i       (q_cmd),
    .q_word_i      (q_word),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .popped_value_o(popped_value_o),
    .found_o       (found_o),
    .position_o    (position_o)
  );

endmodule

/* rtl/core/lss_front.sv */
// front end: input register that accepts beats and classifies the operation
// depends on lss_pkg
module lss_front #(
  parameter int unsigned DATA_WIDTH = lss_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         fr_valid_o,
  input  logic                         fr_stall_i,
  output lss_pkg::cmd_e                fr_cmd_o,
  output logic [DATA_WIDTH-1:0]        fr_word_o
);
  import lss_pkg::*;

  logic                  valid_q, valid_d;
  cmd_e                  cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] word_q;
  logic                  accept;

  // hold the input while the queue is full
  assign in_stall_o = valid_q & fr_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & fr_stall_i);

  // decode the operation code, unused code becomes a no-op
  always_comb begin
    case (op_e'(operation_i))
      OP_PUSH:   cmd_d = CMD_PUSH;
      OP_POP:    cmd_d = CMD_POP;
      OP_SEARCH: cmd_d = CMD_SEARCH;
      default:   cmd_d = CMD_NOP;
    endcase
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_d;
      word_q <= value_i;
    end
  end

  assign fr_valid_o = valid_q;
  assign fr_cmd_o   = cmd_q;
  assign fr_word_o  = word_q;

endmodule

/* rtl/core/lss_queue.sv */
// short command queue between the front end and the back end
// depends on lss_pkg
module lss_queue #(
  parameter int unsigned DATA_WIDTH = lss_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_stall_o,
  input  lss_pkg::cmd_e         wr_cmd_i,
  input  logic [DATA_WIDTH-1:0] wr_word_i,
  output logic                  rd_valid_o,
  input  logic                  rd_stall_i,
  output lss_pkg::cmd_e         rd_cmd_o,
  output logic [DATA_WIDTH-1:0] rd_word_o
);
  import lss_pkg::*;

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  cmd_e                  cmd_q  [QueueDepth];
  logic [DATA_WIDTH-1:0] word_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  push, pop;

  assign wr_stall_o = (cnt_q == CntWidth'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i & ~wr_stall_o;
  assign pop        = rd_valid_o & ~rd_stall_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q]  <= wr_cmd_i;
      word_q[wr_ptr_q] <= wr_word_i;
    end
  end

  assign rd_cmd_o  = cmd_q[rd_ptr_q];
  assign rd_word_o = word_q[rd_ptr_q];

endmodule

/* rtl/core/lss_back.sv */
// back end: stack memory, entry count, search walk and result register
// depends on lss_pkg
module lss_back #(
  parameter int unsigned DEPTH      = lss_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = lss_pkg::DataWidthDef,
  localparam int unsigned CountWidth = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_stall_o,
  input  lss_pkg::cmd_e                q_cmd_i,
  input  logic [DATA_WIDTH-1:0]        q_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lss_pkg::status_e             status_o,
  output logic [CountWidth-1:0]        entry_count_o,
  output logic signed [DATA_WIDTH-1:0] popped_value_o,
  output logic                         found_o,
  output logic [CountWidth-1:0]        position_o
);
  import lss_pkg::*;

  localparam int unsigned AddrWidth = $clog2(DEPTH);

  bk_state_e             state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d, count_dec;
  logic [AddrWidth-1:0]  idx_q, idx_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] entries_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic                  out_free, take, hit, last_idx;
  logic                  mem_we, mem_re;
  logic [AddrWidth-1:0]  mem_raddr;
  logic                  res_load, res_found;
  status_e               res_status;
  logic [DATA_WIDTH-1:0] res_popped;
  logic [CountWidth-1:0] res_pos;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [CountWidth-1:0] out_count_q, out_pos_q;
  logic [DATA_WIDTH-1:0] out_popped_q;
  logic                  out_found_q;

  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign count_dec = count_q - CountWidth'(1);
  assign hit       = (rd_data_q == key_q);
  assign last_idx  = ((CountWidth'(idx_q) + CountWidth'(1)) == count_q);
  assign q_stall_o = ~take;

  // command sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    key_d      = key_q;
    take       = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_popped = '0;
    res_found  = 1'b0;
    res_pos    = '0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i)
            CMD_PUSH: begin
              if (out_free) begin
                take     = 1'b1;
                res_load = 1'b1;
                if (count_q == CountWidth'(DEPTH)) begin
                  res_status = STAT_OVERFLOW;
                end else begin
                  mem_we  = 1'b1;
                  count_d = count_q + CountWidth'(1);
                end
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                if (out_free) begin
                  take       = 1'b1;
                  res_load   = 1'b1;
                  res_status = STAT_UNDERFLOW;
                end
              end else begin
                // read the top entry into the read register, the result loads in BK_POP
                take      = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = count_dec[AddrWidth-1:0];
                count_d   = count_dec;
                state_d   = BK_POP;
              end
            end
            CMD_SEARCH: begin
              if (count_q == '0) begin
                if (out_free) begin
                  take     = 1'b1;
                  res_load = 1'b1;
                end
              end else begin
                // start the walk at the bottom entry
                take      = 1'b1;
                mem_re    = 1'b1;
                idx_d     = '0;
                key_d     = q_word_i;
                state_d   = BK_SEARCH;
              end
            end
            default: begin
              if (out_free) begin
                take     = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      BK_POP: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_popped = rd_data_q;
          state_d    = BK_IDLE;
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          if (out_free) begin
            res_load  = 1'b1;
            res_found = 1'b1;
            res_pos   = CountWidth'(idx_q);
            state_d   = BK_IDLE;
          end
        end else if (last_idx) begin
          if (out_free) begin
            res_load = 1'b1;
            res_pos  = count_q;
            state_d  = BK_IDLE;
          end
        end else begin
          // step to the next entry up
          idx_d     = idx_q + AddrWidth'(1);
          mem_re    = 1'b1;
          mem_raddr = idx_q + AddrWidth'(1);
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // search walk registers and result payload
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    if (res_load) begin
      out_status_q <= res_status;
      out_count_q  <= count_d;
      out_popped_q <= res_popped;
      out_found_q  <= res_found;
      out_pos_q    <= res_pos;
    end
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[count_q[AddrWidth-1:0]] <= q_word_i;
    end
    if (mem_re) begin
      rd_data_q <= entries_q[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign entry_count_o  = out_count_q;
  assign popped_value_o = out_popped_q;
  assign found_o        = out_found_q;
  assign position_o     = out_pos_q;

endmodule

/* rtl/core/lss_checker.sv */
// port-level checker for lifo_stack_with_search, bound to the top level
// depends on lss_pkg and lifo_stack_with_search_macros.svh
`include "lifo_stack_with_search_macros.svh"

module lss_checker #(
  parameter int unsigned DEPTH      = lss_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = lss_pkg::DataWidthDef,
  localparam int unsigned CountWidth = $clog2(DEPTH + 1)
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input lss_pkg::status_e             status_o,
  input logic [CountWidth-1:0]        entry_count_o,
  input logic signed [DATA_WIDTH-1:0] popped_value_o,
  input logic                         found_o,
  input logic [CountWidth-1:0]        position_o
);
  import lss_pkg::*;

  // a stalled result beat holds
  `LSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(entry_count_o) && $stable(popped_value_o) && $stable(found_o) && $stable(position_o))

  // count never passes the capacity
  `LSS_ASSERT_IMP(a_count_bound, out_valid_o, entry_count_o <= CountWidth'(DEPTH))

  // overflow only on a full stack
  `LSS_ASSERT_IMP(a_overflow_full, out_valid_o && status_o == STAT_OVERFLOW, entry_count_o == CountWidth'(DEPTH))

  // underflow only on an empty stack, nothing popped
  `LSS_ASSERT_IMP(a_underflow_empty, out_valid_o && status_o == STAT_UNDERFLOW, entry_count_o == '0 && popped_value_o == '0)

  // a match lies below the count
  `LSS_ASSERT_IMP(a_found_pos, out_valid_o && found_o, position_o < entry_count_o)

endmodule

bind lifo_stack_with_search lss_checker #(
  .DEPTH     (DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_lss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .entry_count_o (entry_count_o),
  .popped_value_o(popped_value_o),
  .found_o       (found_o),
  .position_o    (position_o)
);
